>>> design/uer_pkg.sv
package uer_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND_SPEED   = 2'd2;

  localparam int TRIG_W = 8;
  localparam int TICK_W = 18;
  localparam int SPEED_W = 9;
  localparam int WIDTH_W = 16;
  localparam int ROUND_W = 4;
  localparam int DIST_W = 17;
  // The quotient of the running width*speed product: it stays below 2^18 for every
  // sample count, since at most SAMPLES saturated widths are averaged.
  localparam int QUOT_W = 18;

  localparam logic [TRIG_W-1:0]  TRIGGER_RESET = 8'd15;
  localparam logic [TICK_W-1:0]  SETTLE_RESET  = 18'd60000;
  localparam logic [SPEED_W-1:0] SPEED_RESET   = 9'd347;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = 16'hFFFF;
  localparam logic [DIST_W-1:0]  DIST_MAX  = 17'h1FFFF;

  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int IN_ECHO_BIT = 0;
  localparam int IN_START_BIT = 1;
  localparam int OUT_TRIG_BIT = 0;
  localparam int OUT_BUSY_BIT = 1;
  localparam int OUT_DONE_BIT = 2;
  localparam int OUT_DIST_LSB = 3;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_LOW  = 3'd1,
    PH_TRIG      = 3'd2,
    PH_WAIT_HIGH = 3'd3,
    PH_MEASURE   = 3'd4,
    PH_SETTLE    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [TRIG_W-1:0]  trigger_ticks;
    logic [TICK_W-1:0]  settle_ticks;
    logic [SPEED_W-1:0] sound_speed;
  } cfg_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic [DIST_W-1:0] distance;
  } res_t;

endpackage

>>> design/uer_core.sv
module uer_core #(
  parameter int SAMPLES = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          echo_level,
  input  logic          start_req,
  input  uer_pkg::cfg_t cfg,
  output uer_pkg::res_t res
);
  import uer_pkg::*;

  localparam int DIV = 200 * SAMPLES;
  localparam int RW = $clog2(DIV);
  localparam int DW = $clog2(2 * DIV + 1);

  phase_t               phase, phase_next;
  logic [TICK_W-1:0]    tick_count, tick_count_next;
  logic [WIDTH_W-1:0]   echo_width, echo_width_next;
  logic [ROUND_W-1:0]   rounds_done, rounds_done_next;
  logic [DIST_W-1:0]    last_distance, last_distance_next;
  logic [QUOT_W-1:0]    acc_q, acc_q_next;
  logic [RW-1:0]        acc_r, acc_r_next;
  logic                 done_next;

  logic [DW-1:0]        spd_x;
  logic [1:0]           spd_q;
  logic [RW-1:0]        spd_r;
  logic [RW:0]          r_sum;
  logic                 r_carry;
  logic [QUOT_W-1:0]    q_inc;
  logic [RW-1:0]        r_inc;

  // Split the speed into a whole and a fractional part of the divisor so the
  // running average advances by one speed step per counted echo tick.
  assign spd_x = DW'(cfg.sound_speed);

  always_comb begin
    if (spd_x >= DW'(2 * DIV)) begin
      spd_q = 2'd2;
      spd_r = RW'(spd_x - DW'(2 * DIV));
    end else if (spd_x >= DW'(DIV)) begin
      spd_q = 2'd1;
      spd_r = RW'(spd_x - DW'(DIV));
    end else begin
      spd_q = 2'd0;
      spd_r = RW'(spd_x);
    end
  end

  assign r_sum   = {1'b0, acc_r} + (RW+1)'(spd_r);
  assign r_carry = (r_sum >= (RW+1)'(DIV));
  assign r_inc   = r_carry ? RW'(r_sum - (RW+1)'(DIV)) : RW'(r_sum);
  assign q_inc   = acc_q + QUOT_W'(spd_q) + QUOT_W'(r_carry);

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    echo_width_next    = echo_width;
    rounds_done_next   = rounds_done;
    last_distance_next = last_distance;
    acc_q_next         = acc_q;
    acc_r_next         = acc_r;
    done_next          = 1'b0;
    unique case (phase)
      PH_WAIT_LOW: begin
        if (!echo_level) begin
          phase_next      = PH_TRIG;
          tick_count_next = TICK_W'(1);
        end
      end
      PH_TRIG: begin
        if (tick_count >= TICK_W'(cfg.trigger_ticks)) begin
          phase_next = PH_WAIT_HIGH;
        end else begin
          tick_count_next = tick_count + TICK_W'(1);
        end
      end
      PH_WAIT_HIGH: begin
        if (echo_level) begin
          phase_next      = PH_MEASURE;
          echo_width_next = WIDTH_W'(1);
          acc_q_next      = q_inc;
          acc_r_next      = r_inc;
        end
      end
      PH_MEASURE: begin
        if (echo_level) begin
          // hold the width once it saturates
          if (echo_width != WIDTH_MAX) begin
            echo_width_next = echo_width + WIDTH_W'(1);
            acc_q_next      = q_inc;
            acc_r_next      = r_inc;
          end
        end else begin
          rounds_done_next = rounds_done + ROUND_W'(1);
          tick_count_next  = '0;
          phase_next       = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        if (tick_count >= cfg.settle_ticks) begin
          if (rounds_done >= ROUND_W'(SAMPLES)) begin
            last_distance_next = (acc_q > QUOT_W'(DIST_MAX)) ? DIST_MAX
                                                              : acc_q[DIST_W-1:0];
            done_next  = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_WAIT_LOW;
          end
        end else begin
          tick_count_next = tick_count + TICK_W'(1);
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (start_req) begin
          acc_q_next       = '0;
          acc_r_next       = '0;
          rounds_done_next = '0;
          echo_width_next  = '0;
          tick_count_next  = '0;
          phase_next       = PH_WAIT_LOW;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      echo_width    <= '0;
      rounds_done   <= '0;
      last_distance <= '0;
      acc_q         <= '0;
      acc_r         <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      echo_width    <= echo_width_next;
      rounds_done   <= rounds_done_next;
      last_distance <= last_distance_next;
      acc_q         <= acc_q_next;
      acc_r         <= acc_r_next;
    end
  end

  assign res.trigger_level = (phase_next == PH_TRIG);
  assign res.busy_res      = (phase_next != PH_IDLE);
  assign res.done_res      = done_next;
  assign res.distance      = last_distance_next;

endmodule

>>> design/ultrasonic_echo_ranger_unit.sv
// Channel   | Direction | Payload (lowest bit first)
// s_axis    | in        | echo_level, start_req (one microsecond tick)
// m_axis    | out       | trigger_level, busy_res, done_res, distance[16:0]
// cfg       | in        | cfg_index 0 trigger_ticks, 1 settle_ticks, 2 sound_speed
//
// One tick is taken every cycle unless stalled; the output register holds its
// result the next cycle, set by the phase sequencer and running average update.
// Reset (rst, synchronous) returns the sequencer to idle, clears the distance
// and loads the register defaults 15, 60000 and 347.
// With m_axis_tready low the result holds and s_axis_tready drops only while
// the output register is full and not taken.
module ultrasonic_echo_ranger_unit #(
  parameter int SAMPLES = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] echo_level, [1] start_req, [7:2] zero
  input  logic [uer_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] trigger_level, [1] busy_res, [2] done_res, [19:3] distance, [23:20] zero
  output logic [uer_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_wr_en,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import uer_pkg::*;

  cfg_t cfg;
  res_t res;
  logic step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_ticks <= TRIGGER_RESET;
      cfg.settle_ticks  <= SETTLE_RESET;
      cfg.sound_speed   <= SPEED_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TRIGGER_TICKS: cfg.trigger_ticks <= cfg_wdata[TRIG_W-1:0];
        CFG_SETTLE_TICKS:  cfg.settle_ticks  <= cfg_wdata[TICK_W-1:0];
        CFG_SOUND_SPEED:   cfg.sound_speed   <= cfg_wdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;

  uer_core #(
    .SAMPLES(SAMPLES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .echo_level (s_axis_tdata[IN_ECHO_BIT]),
    .start_req  (s_axis_tdata[IN_START_BIT]),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {(OUT_TDATA_W-DIST_W-3)'(0), res.distance, res.done_res,
                       res.busy_res, res.trigger_level};
    end
  end

endmodule

>>> design/uer_checker.sv
module uer_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [uer_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import uer_pkg::*;

  // a completed measurement leaves the sequencer idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[OUT_DONE_BIT] |-> !m_axis_tdata[OUT_BUSY_BIT])
    else $error("done reported while busy");

  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[OUT_TRIG_BIT] |-> m_axis_tdata[OUT_BUSY_BIT])
    else $error("trigger driven outside a sequence");

  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed during stall");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
